### hw/rtl/bft_pkg.sv
package bft_pkg;

    localparam int NUM_FUNCS       = 8;
    localparam int POINTS_PER_FUNC = 32;
    localparam int COORD_BITS      = 16;

    localparam int FUNC_W = $clog2(NUM_FUNCS);
    localparam int IDX_W  = $clog2(POINTS_PER_FUNC);
    localparam int CNT_W  = $clog2(POINTS_PER_FUNC + 1);
    localparam int FIU_W  = $clog2(NUM_FUNCS + 1);
    localparam int ADDR_W = FUNC_W + IDX_W;
    localparam int DIV_W  = 2 * COORD_BITS + 1;

    localparam logic [15:0] TOL_RESET = 16'd655;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_EVAL   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOMATCH = 2'd2;

    typedef struct packed {
        t_op                   op;
        logic [2:0]            func;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] value;
        logic [1:0]  status;
        logic        last;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVF,
        S_RD,
        S_USE,
        S_ISH_RD,
        S_ISH_WR,
        S_PUT,
        S_RSH_RD,
        S_RSH_WR,
        S_MUL,
        S_DIVS,
        S_DIVW,
        S_OUT
    } t_state;

endpackage

### hw/rtl/bft_front.sv
module bft_front import bft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_func_index,
    input  logic [15:0] i_x_pos,
    input  logic [15:0] i_y_pos,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_ack
);

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;
    t_cmd       cmd_in;

    always_comb begin
        cmd_in.op   = t_op'(i_op);
        cmd_in.func = i_func_index;
        cmd_in.x    = i_x_pos[COORD_BITS-1:0];
        cmd_in.y    = i_y_pos[COORD_BITS-1:0];
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign wr          = push && !full;
    assign rd          = i_cmd_ack && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= ~r_wp;
            if (rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_q[r_wp] <= cmd_in;
    end

endmodule

### hw/rtl/bft_div.sv
module bft_div import bft_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIV_W-1:0]      i_num,
    input  logic [COORD_BITS-1:0] i_den,
    output logic                  o_done,
    output logic [DIV_W-1:0]      o_quo
);

    localparam int STEP_W = $clog2(DIV_W + 1);

    logic                  r_busy, r_done;
    logic [STEP_W-1:0]     r_step;
    logic [COORD_BITS-1:0] r_rem, r_den;
    logic [DIV_W-1:0]      r_quo;
    logic [COORD_BITS:0]   sh, diff;
    logic                  ge;

    assign sh   = {r_rem, r_quo[DIV_W-1]};
    assign ge   = (sh >= {1'b0, r_den});
    assign diff = sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIV_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_W-2:0], ge};
            r_rem <= ge ? diff[COORD_BITS-1:0] : sh[COORD_BITS-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

### hw/rtl/bft_outq.sv
module bft_outq import bft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_res_push,
    input  t_res        i_res,
    output logic        o_res_full,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_out_func,
    output logic [15:0] o_value,
    output logic [1:0]  o_status,
    output logic        o_last
);

    t_res       r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr, rd;
    t_res       head;

    assign o_res_full = (r_cnt == 3'd4);
    assign empty      = (r_cnt == 3'd0);
    assign wr         = i_res_push && !o_res_full;
    assign rd         = pop && !empty;
    assign head       = r_q[r_rp];
    assign o_out_func = head.func;
    assign o_value    = head.value;
    assign o_status   = head.status;
    assign o_last     = head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, wr} - {2'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_q[r_wp] <= i_res;
    end

endmodule

### hw/rtl/bft_back.sv
module bft_back import bft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_ack,
    output logic        o_res_push,
    output t_res        o_res,
    input  logic        i_res_full
);

    localparam int CB = COORD_BITS;

    logic [2*CB-1:0] mem [NUM_FUNCS*POINTS_PER_FUNC];
    logic [2*CB-1:0] r_rdata;
    logic            mem_re, mem_we;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;
    logic [2*CB-1:0] mem_wdata;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [CNT_W-1:0] r_cnt [NUM_FUNCS];
    logic [CNT_W-1:0] n_cnt [NUM_FUNCS];
    logic [FIU_W-1:0] r_fiu, n_fiu;
    logic [15:0]      r_tol, n_tol;
    logic [CNT_W-1:0] r_k, n_k, r_pos, n_pos;
    logic [FUNC_W-1:0] r_fn, n_fn;
    logic [CB-1:0]    r_px, n_px, r_py, n_py;
    logic             r_found, n_found;
    logic [IDX_W-1:0] r_best, n_best;
    logic [CB:0]      r_bd, n_bd;
    logic [CB-1:0]    r_den, n_den, r_dy, n_dy, r_dxx, n_dxx, r_yl, n_yl;
    logic             r_up, n_up;
    logic [2*CB-1:0]  r_prod, n_prod;
    t_res             r_res, n_res;

    logic              div_start, div_done;
    logic [DIV_W-1:0]  div_quo;
    logic [FUNC_W-1:0] fn_sel;
    logic [CNT_W-1:0]  cur_n;
    logic [CB-1:0]     d_x, d_y, ax, ay;
    logic              last_k, brk, match;
    logic [CB:0]       dsum;

    bft_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({1'b0, r_prod} + DIV_W'(r_den >> 1)),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_cfg_ready = 1'b1;
    assign o_res       = r_res;
    assign fn_sel      = (r_cmd.op == OP_EVAL) ? r_fn : r_cmd.func[FUNC_W-1:0];
    assign cur_n       = r_cnt[fn_sel];
    assign d_x         = r_rdata[2*CB-1:CB];
    assign d_y         = r_rdata[CB-1:0];
    assign last_k      = (r_k == cur_n - CNT_W'(1));
    assign brk         = (r_cmd.x >= r_px) && (r_cmd.x <= d_x);
    assign ax          = (r_cmd.x >= d_x) ? r_cmd.x - d_x : d_x - r_cmd.x;
    assign ay          = (r_cmd.y >= d_y) ? r_cmd.y - d_y : d_y - r_cmd.y;
    assign dsum        = {1'b0, ax} + {1'b0, ay};
    assign match       = (ax < r_tol) && (ay < r_tol);

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fiu   <= FIU_W'(1);
            r_tol   <= TOL_RESET;
            for (int i = 0; i < NUM_FUNCS; i++) r_cnt[i] <= '0;
        end else begin
            r_state <= n_state;
            r_fiu   <= n_fiu;
            r_tol   <= n_tol;
            for (int i = 0; i < NUM_FUNCS; i++) r_cnt[i] <= n_cnt[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_k     <= n_k;
        r_pos   <= n_pos;
        r_fn    <= n_fn;
        r_px    <= n_px;
        r_py    <= n_py;
        r_found <= n_found;
        r_best  <= n_best;
        r_bd    <= n_bd;
        r_den   <= n_den;
        r_dy    <= n_dy;
        r_dxx   <= n_dxx;
        r_yl    <= n_yl;
        r_up    <= n_up;
        r_prod  <= n_prod;
        r_res   <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_cnt   = r_cnt;
        n_fiu   = r_fiu;
        n_tol   = (i_cfg_valid) ? i_cfg_data : r_tol;
        n_k     = r_k;
        n_pos   = r_pos;
        n_fn    = r_fn;
        n_px    = r_px;
        n_py    = r_py;
        n_found = r_found;
        n_best  = r_best;
        n_bd    = r_bd;
        n_den   = r_den;
        n_dy    = r_dy;
        n_dxx   = r_dxx;
        n_yl    = r_yl;
        n_up    = r_up;
        n_prod  = r_prod;
        n_res   = r_res;
        o_cmd_ack  = 1'b0;
        o_res_push = 1'b0;
        div_start  = 1'b0;
        mem_re     = 1'b0;
        mem_we     = 1'b0;
        mem_raddr  = {fn_sel, r_k[IDX_W-1:0]};
        mem_waddr  = {fn_sel, r_k[IDX_W-1:0]};
        mem_wdata  = r_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_ack  = 1'b1;
                    n_cmd      = i_cmd;
                    n_res.func = i_cmd.func;
                    n_res.value = '0;
                    n_res.status = ST_OK;
                    n_res.last = 1'b1;
                    n_k        = '0;
                    n_found    = 1'b0;
                    case (i_cmd.op)
                        OP_INSERT: begin
                            if (FIU_W'(i_cmd.func) + FIU_W'(1) > r_fiu)
                                n_fiu = FIU_W'(i_cmd.func) + FIU_W'(1);
                            if (r_cnt[i_cmd.func] == CNT_W'(POINTS_PER_FUNC)) begin
                                n_res.status = ST_FULL;
                                n_state = S_OUT;
                            end else if (r_cnt[i_cmd.func] == '0) begin
                                n_pos   = '0;
                                n_state = S_PUT;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_cnt[i_cmd.func] == '0) begin
                                n_res.status = ST_NOMATCH;
                                n_state = S_OUT;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                        OP_EVAL: begin
                            n_fn    = '0;
                            n_state = S_EVF;
                        end
                        default: begin
                            for (int i = 0; i < NUM_FUNCS; i++) n_cnt[i] = '0;
                            n_res.func = '0;
                            n_state    = S_OUT;
                        end
                    endcase
                end
            end
            S_EVF: begin
                n_res.func   = r_fn;
                n_res.value  = '0;
                n_res.status = ST_OK;
                n_res.last   = (FIU_W'(r_fn) + FIU_W'(1) == r_fiu);
                n_k          = '0;
                if (cur_n == '0) n_state = S_OUT;
                else             n_state = S_RD;
            end
            S_RD: begin
                mem_re  = 1'b1;
                n_state = S_USE;
            end
            S_USE: begin
                n_px    = d_x;
                n_py    = d_y;
                n_k     = r_k + CNT_W'(1);
                n_state = S_RD;
                case (r_cmd.op)
                    OP_INSERT: begin
                        if (r_k == '0 && r_cmd.x < d_x) begin
                            n_pos = '0;
                            n_k   = cur_n;
                            n_state = S_ISH_RD;
                        end else if (r_k != '0 && brk) begin
                            n_pos = r_k;
                            n_k   = cur_n;
                            n_state = S_ISH_RD;
                        end else if (last_k) begin
                            n_pos = cur_n;
                            n_k   = cur_n;
                            n_state = S_PUT;
                        end
                    end
                    OP_REMOVE: begin
                        if (match && (!r_found || dsum < r_bd)) begin
                            n_found = 1'b1;
                            n_bd    = dsum;
                            n_best  = r_k[IDX_W-1:0];
                        end
                        if (last_k) begin
                            if (n_found) begin
                                n_k     = CNT_W'(n_best);
                                n_state = S_RSH_RD;
                            end else begin
                                n_res.status = ST_NOMATCH;
                                n_state = S_OUT;
                            end
                        end
                    end
                    default: begin
                        if (r_k == '0 && r_cmd.x < d_x) begin
                            n_state = S_OUT;
                        end else if (r_k != '0 && brk) begin
                            if (d_x <= r_px) begin
                                n_res.value = 16'(r_py);
                                n_state = S_OUT;
                            end else begin
                                n_den   = d_x - r_px;
                                n_up    = (d_y >= r_py);
                                n_dy    = (d_y >= r_py) ? d_y - r_py : r_py - d_y;
                                n_dxx   = r_cmd.x - r_px;
                                n_yl    = r_py;
                                n_state = S_MUL;
                            end
                        end else if (last_k) begin
                            n_state = S_OUT;
                        end
                    end
                endcase
            end
            S_ISH_RD: begin
                if (r_k > r_pos) begin
                    mem_re    = 1'b1;
                    mem_raddr = {fn_sel, r_k[IDX_W-1:0] - IDX_W'(1)};
                    n_state   = S_ISH_WR;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_ISH_WR: begin
                mem_we  = 1'b1;
                n_k     = r_k - CNT_W'(1);
                n_state = S_ISH_RD;
            end
            S_PUT: begin
                mem_we    = 1'b1;
                mem_waddr = {fn_sel, r_pos[IDX_W-1:0]};
                mem_wdata = {r_cmd.x, r_cmd.y};
                n_cnt[fn_sel] = cur_n + CNT_W'(1);
                n_state   = S_OUT;
            end
            S_RSH_RD: begin
                if (r_k + CNT_W'(1) < cur_n) begin
                    mem_re    = 1'b1;
                    mem_raddr = {fn_sel, r_k[IDX_W-1:0] + IDX_W'(1)};
                    n_state   = S_RSH_WR;
                end else begin
                    n_cnt[fn_sel] = cur_n - CNT_W'(1);
                    n_state = S_OUT;
                end
            end
            S_RSH_WR: begin
                mem_we  = 1'b1;
                n_k     = r_k + CNT_W'(1);
                n_state = S_RSH_RD;
            end
            S_MUL: begin
                n_prod  = r_dy * r_dxx;
                n_state = S_DIVS;
            end
            S_DIVS: begin
                div_start = 1'b1;
                n_state   = S_DIVW;
            end
            S_DIVW: begin
                if (div_done) begin
                    n_res.value = r_up ? 16'(r_yl + div_quo[CB-1:0])
                                       : 16'(r_yl - div_quo[CB-1:0]);
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (r_cmd.op == OP_EVAL && !r_res.last) begin
                        n_fn    = r_fn + FUNC_W'(1);
                        n_state = S_EVF;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### hw/rtl/breakpoint_function_table.sv
// channel  direction  handshake                 payload
// input    in         push / full               i_op i_func_index i_x_pos i_y_pos
// result   out        empty / pop               o_out_func o_value o_status o_last
// config   in         i_cfg_valid / o_cfg_ready i_cfg_data (select tolerance)
//
// one item at a time through the sequencer, two-deep input queue, four-deep result queue
// insert shifts later points up, remove shifts later points down, clear zeroes counts
// evaluate per function: list scan on one ram port, 33-step divider
// synchronous active-low reset clears counts and queues; point ram is not cleared
// a full result queue stalls the sequencer; input keeps queuing until its queue fills
module breakpoint_function_table import bft_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_op,
    input  logic [2:0]  i_func_index,
    input  logic [15:0] i_x_pos,
    input  logic [15:0] i_y_pos,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_out_func,
    output logic [15:0] o_value,
    output logic [1:0]  o_status,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic cmd_valid, cmd_ack, res_push, res_full;
    t_cmd cmd;
    t_res res;

    bft_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_op         (i_op),
        .i_func_index (i_func_index),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_ack    (cmd_ack)
    );

    bft_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_ack   (cmd_ack),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    bft_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res_push (res_push),
        .i_res      (res),
        .o_res_full (res_full),
        .empty      (empty),
        .pop        (pop),
        .o_out_func (o_out_func),
        .o_value    (o_value),
        .o_status   (o_status),
        .o_last     (o_last)
    );

endmodule

### hw/rtl/bft_checker.sv
module bft_checker import bft_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_out_func,
    input logic [15:0] o_value,
    input logic [1:0]  o_status,
    input logic        o_last
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status == ST_OK || o_status == ST_FULL || o_status == ST_NOMATCH))
        else $error("bad status code");

    a_err_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_OK) |-> (o_value == '0 && o_last))
        else $error("error result carries value or is not last");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_value) && $stable(o_out_func)))
        else $error("stalled result changed");

endmodule

bind breakpoint_function_table bft_checker u_chk (.*);

### bench/breakpoint_function_table_test.sv
`timescale 1ns / 100ps

class table_tracker;
    logic [15:0] pt_x [bft_pkg::NUM_FUNCS*bft_pkg::POINTS_PER_FUNC];
    logic [15:0] pt_y [bft_pkg::NUM_FUNCS*bft_pkg::POINTS_PER_FUNC];
    int          n_points [bft_pkg::NUM_FUNCS];
    int          funcs_used;
    logic [15:0] tolerance;
    bft_pkg::t_res pending_results[$];
    int          errors;

    function new();
        foreach (n_points[i]) n_points[i] = 0;
        funcs_used = 1;
        tolerance  = bft_pkg::TOL_RESET;
        errors     = 0;
    endfunction

    function logic [15:0] interpolate(int f, logic [15:0] x);
        int base;
        longint unsigned xl, xr, yl, yr, den, dx;
        base = f * bft_pkg::POINTS_PER_FUNC;
        if (n_points[f] == 0 || x < pt_x[base]) return 16'd0;
        for (int k = 0; k + 1 < n_points[f]; k++) begin
            xl = pt_x[base+k];
            xr = pt_x[base+k+1];
            yl = pt_y[base+k];
            yr = pt_y[base+k+1];
            if (x >= xl && x <= xr) begin
                if (xr <= xl) return yl[15:0];
                den = xr - xl;
                dx  = x - xl;
                if (yr >= yl) return 16'(yl + ((yr - yl) * dx + den / 2) / den);
                return 16'(yl - ((yl - yr) * dx + den / 2) / den);
            end
        end
        return 16'd0;
    endfunction

    function logic [1:0] add_point(int f, logic [15:0] x, logic [15:0] y);
        int base, n, pos;
        if (f + 1 > funcs_used) funcs_used = f + 1;
        n = n_points[f];
        if (n >= bft_pkg::POINTS_PER_FUNC) return bft_pkg::ST_FULL;
        base = f * bft_pkg::POINTS_PER_FUNC;
        if (n == 0 || x < pt_x[base]) pos = 0;
        else begin
            pos = n;
            for (int k = 0; k + 1 < n; k++)
                if (x >= pt_x[base+k] && x <= pt_x[base+k+1]) begin
                    pos = k + 1;
                    break;
                end
        end
        for (int k = n; k > pos; k--) begin
            pt_x[base+k] = pt_x[base+k-1];
            pt_y[base+k] = pt_y[base+k-1];
        end
        pt_x[base+pos] = x;
        pt_y[base+pos] = y;
        n_points[f] = n + 1;
        return bft_pkg::ST_OK;
    endfunction

    function logic [1:0] drop_point(int f, logic [15:0] x, logic [15:0] y);
        int base, n, best;
        bit found;
        int dx, dy, best_d;
        n = n_points[f];
        base = f * bft_pkg::POINTS_PER_FUNC;
        found = 0;
        best = 0;
        best_d = 0;
        for (int k = 0; k < n; k++) begin
            dx = int'(x) - int'(pt_x[base+k]);
            dy = int'(y) - int'(pt_y[base+k]);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            if (dx < tolerance && dy < tolerance && (!found || dx + dy < best_d)) begin
                found = 1;
                best_d = dx + dy;
                best = k;
            end
        end
        if (!found) return bft_pkg::ST_NOMATCH;
        for (int k = best; k + 1 < n; k++) begin
            pt_x[base+k] = pt_x[base+k+1];
            pt_y[base+k] = pt_y[base+k+1];
        end
        n_points[f] = n - 1;
        return bft_pkg::ST_OK;
    endfunction

    function void note_item(bft_pkg::t_op op, logic [2:0] f, logic [15:0] x, logic [15:0] y);
        bft_pkg::t_res r;
        r = '{func: f, value: 16'd0, status: bft_pkg::ST_OK, last: 1'b1};
        case (op)
            bft_pkg::OP_INSERT: begin
                r.status = add_point(f, x, y);
                pending_results.push_back(r);
            end
            bft_pkg::OP_REMOVE: begin
                r.status = drop_point(f, x, y);
                pending_results.push_back(r);
            end
            bft_pkg::OP_EVAL: begin
                for (int i = 0; i < funcs_used; i++) begin
                    r.func  = 3'(i);
                    r.value = interpolate(i, x);
                    r.last  = (i + 1 == funcs_used);
                    pending_results.push_back(r);
                end
            end
            default: begin
                foreach (n_points[i]) n_points[i] = 0;
                r.func = 3'd0;
                pending_results.push_back(r);
            end
        endcase
    endfunction

    function void check_result(bft_pkg::t_res got);
        bft_pkg::t_res want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (got.func !== want.func)
            $display("%0t: out_func expected %0d actual %0d", $time, want.func, got.func);
        if (got.value !== want.value)
            $display("%0t: value expected %0d actual %0d", $time, want.value, got.value);
        if (got.status !== want.status)
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        if (got.last !== want.last)
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        if (got !== want) errors++;
    endfunction
endclass

module breakpoint_function_table_test;
    import bft_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        push = 0;
    logic        full;
    logic [1:0]  i_op = 0;
    logic [2:0]  i_func_index = 0;
    logic [15:0] i_x_pos = 0;
    logic [15:0] i_y_pos = 0;
    logic        empty;
    logic        pop = 0;
    logic [2:0]  o_out_func;
    logic [15:0] o_value;
    logic [1:0]  o_status;
    logic        o_last;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = 0;

    table_tracker tracker = new();
    int idle_pct = 0;
    int stall_pct = 0;
    longint cycles = 0;

    breakpoint_function_table uut (.*);

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge i_clk) pop = ($urandom_range(99) >= stall_pct);

    always @(posedge i_clk)
        if (i_rst_n && pop && !empty)
            tracker.check_result('{func: o_out_func, value: o_value, status: o_status,
                                   last: o_last});

    task automatic send_item(t_op op, logic [2:0] f, logic [15:0] x, logic [15:0] y);
        while ($urandom_range(99) < idle_pct) begin
            push = 0;
            @(negedge i_clk);
        end
        push = 1;
        i_op = op;
        i_func_index = f;
        i_x_pos = x;
        i_y_pos = y;
        do @(posedge i_clk); while (full);
        tracker.note_item(op, f, x, y);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        push = 0;
        while (tracker.pending_results.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_tolerance(logic [15:0] v);
        i_cfg_valid = 1;
        i_cfg_data = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        tracker.tolerance = v;
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    task automatic random_items(int count);
        int r, f, k;
        logic [15:0] x, y;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            f = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(3);
            x = 16'($urandom);
            y = 16'($urandom);
            if (r < 45) send_item(OP_INSERT, 3'(f), x, y);
            else if (r < 68) begin
                if (tracker.n_points[f] > 0 && $urandom_range(3) != 0) begin
                    k = f * POINTS_PER_FUNC + $urandom_range(tracker.n_points[f] - 1);
                    x = tracker.pt_x[k] + 16'($urandom_range(600)) - 16'd300;
                    y = tracker.pt_y[k] + 16'($urandom_range(600)) - 16'd300;
                end
                send_item(OP_REMOVE, 3'(f), x, y);
            end else if (r < 97) send_item(OP_EVAL, 3'(f), x, y);
            else send_item(OP_CLEAR, 3'(f), x, y);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed
        send_item(OP_EVAL, 3'd0, 16'd100, 16'd0);
        send_item(OP_INSERT, 3'd0, 16'd0, 16'd0);
        send_item(OP_INSERT, 3'd0, 16'hFFFF, 16'hFFFF);
        send_item(OP_INSERT, 3'd0, 16'd32768, 16'd100);
        send_item(OP_EVAL, 3'd0, 16'd0, 16'd0);
        send_item(OP_EVAL, 3'd0, 16'hFFFF, 16'd0);
        send_item(OP_EVAL, 3'd0, 16'd40001, 16'd0);
        send_item(OP_EVAL, 3'd0, 16'd12345, 16'd0);
        send_item(OP_INSERT, 3'd1, 16'd1000, 16'd500);
        send_item(OP_EVAL, 3'd0, 16'd1000, 16'd0);
        send_item(OP_INSERT, 3'd1, 16'd1000, 16'd900);
        send_item(OP_INSERT, 3'd1, 16'd3, 16'd7);
        send_item(OP_EVAL, 3'd0, 16'd1000, 16'd0);
        send_item(OP_EVAL, 3'd0, 16'd2, 16'd0);
        send_item(OP_INSERT, 3'd7, 16'h5555, 16'hAAAA);
        send_item(OP_INSERT, 3'd7, 16'hAAAA, 16'h5555);
        send_item(OP_EVAL, 3'd7, 16'h8000, 16'd0);
        send_item(OP_REMOVE, 3'd0, 16'd20000, 16'd20000);
        send_item(OP_REMOVE, 3'd0, 16'd32900, 16'd1);
        send_item(OP_REMOVE, 3'd4, 16'd0, 16'd0);
        send_item(OP_CLEAR, 3'd5, 16'hFFFF, 16'hFFFF);
        send_item(OP_EVAL, 3'd0, 16'h8000, 16'd0);
        wait_drained();

        // fill one list past its size
        write_tolerance(16'd0);
        for (int i = 0; i < POINTS_PER_FUNC + 2; i++)
            send_item(OP_INSERT, 3'd5, 16'($urandom), 16'($urandom));
        send_item(OP_REMOVE, 3'd5, tracker.pt_x[5*POINTS_PER_FUNC],
                  tracker.pt_y[5*POINTS_PER_FUNC]);
        send_item(OP_EVAL, 3'd0, 16'($urandom), 16'd0);
        random_items(40);
        wait_drained();

        write_tolerance(16'hFFFF);
        idle_pct = 58;
        random_items(60);
        wait_drained();

        write_tolerance(16'd655);
        idle_pct = 0;
        stall_pct = 58;
        random_items(60);
        wait_drained();

        write_tolerance(16'($urandom_range(2000)));
        idle_pct = 13;
        stall_pct = 13;
        random_items(60);
        wait_drained();

        repeat (200) @(negedge i_clk);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
